FILE: rtl/core/b64d_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 stream decoder.
// No dependencies.
`default_nettype none

package b64d_pkg;

  // Result kind codes as seen on the kind port
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // All results caused by one character, queued as one entry
  typedef struct packed {
    logic [1:0]  nbytes;    // data bytes, most significant first
    logic [23:0] word;      // decoded 24-bit group
    logic        has_tail;  // a done or error result follows the bytes
    logic [1:0]  tail_kind;
    logic [15:0] count;     // byte count for a done result
  } bundle_t;

  // Map a character to {not_in_alphabet, sextet}
  function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
    logic [6:0] r;
    r = {1'b1, 6'd0};
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b0, 6'd63};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/base64_stream_decoder.sv
// Base64 stream decoder, one character per request. Results cross the bundle queue and
// then the serializer register. Throughput: one character per cycle; the output gives
// one result per cycle while out_stall is low, so a final group (up to four results)
// holds the input once the two-entry bundle queue fills. Synchronous reset clears group
// state, the byte count, the queue and the output; no clearing pass is needed.
`default_nettype none

module base64_stream_decoder import b64d_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  character,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [15:0]      byte_count,
  output logic             last_of_run
);

  logic    take;
  logic    push;
  logic    pop;
  logic    full;
  logic    not_empty;
  bundle_t bundle;
  bundle_t head;

  // Accept a request whenever the queue has room
  assign in_stall = full;
  assign take     = in_valid && !full;

  b64d_decode #(
    .COUNT_BITS(COUNT_BITS)
  ) u_decode (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .character     (character),
    .end_of_message(end_of_message),
    .push          (push),
    .bundle        (bundle)
  );

  b64d_bundle_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(bundle),
    .pop      (pop),
    .full     (full),
    .not_empty(not_empty),
    .head     (head)
  );

  b64d_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .avail      (not_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .data_byte  (data_byte),
    .byte_count (byte_count),
    .last_of_run(last_of_run)
  );

endmodule

`default_nettype wire

FILE: rtl/core/b64d_decode.sv
// Per-character decode: group state, pad and error checks, byte count.
// Depends on b64d_pkg; produces one result bundle per request that has results.
`default_nettype none

module b64d_decode import b64d_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] character,
  input  wire logic       end_of_message,
  output logic            push,
  output bundle_t         bundle
);

  logic [17:0]           acc;
  logic [1:0]            group_pos;
  logic [1:0]            pad_count;
  logic                  discarding;
  logic [COUNT_BITS-1:0] total;

  logic [17:0]           acc_next;
  logic [1:0]            group_pos_next;
  logic [1:0]            pad_count_next;
  logic                  discarding_next;
  logic [COUNT_BITS-1:0] total_next;

  logic [6:0]            lookup;
  logic                  is_pad;
  logic [2:0]            pad_new;
  logic [5:0]            sextet;
  logic                  err;
  logic [1:0]            nbytes;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] sat_total;
  logic [15:0]           count16;

  // Classify the character
  assign lookup  = sextet_lookup(character);
  assign is_pad  = (character == PAD_CHAR);
  assign pad_new = {1'b0, pad_count} + {2'b00, is_pad};
  assign sextet  = is_pad ? 6'd0 : lookup[5:0];

  always_comb begin
    if (is_pad) begin
      err = (pad_new > 3'd2);
    end else begin
      err = (pad_count != 2'd0) || lookup[6];
    end
    if (!err && group_pos == 2'd3 && pad_new != 3'd0 && !end_of_message) begin
      err = 1'b1;
    end
    if (!err && group_pos != 2'd3 && end_of_message) begin
      err = 1'b1;
    end
  end

  // Saturating running byte count
  assign nbytes    = 2'(3'd3 - pad_new);
  assign sum       = {1'b0, total} + (COUNT_BITS + 1)'(nbytes);
  assign sat_total = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

  generate
    if (COUNT_BITS > 16) begin : g_clip
      assign count16 = (sat_total[COUNT_BITS-1:16] != '0) ? 16'hFFFF : sat_total[15:0];
    end else begin : g_extend
      assign count16 = 16'(sat_total);
    end
  endgenerate

  // Next state and bundle
  always_comb begin
    acc_next        = acc;
    group_pos_next  = group_pos;
    pad_count_next  = pad_count;
    discarding_next = discarding;
    total_next      = total;
    push            = 1'b0;
    bundle.nbytes    = 2'd0;
    bundle.word      = {acc, sextet};
    bundle.has_tail  = 1'b0;
    bundle.tail_kind = KIND_ERROR;
    bundle.count     = 16'd0;
    if (take) begin
      if (discarding) begin
        // drop everything up to the end of the message
        if (end_of_message) begin
          acc_next        = '0;
          group_pos_next  = '0;
          pad_count_next  = '0;
          discarding_next = 1'b0;
          total_next      = '0;
        end
      end else if (err) begin
        push             = 1'b1;
        bundle.has_tail  = 1'b1;
        bundle.tail_kind = KIND_ERROR;
        acc_next         = '0;
        group_pos_next   = '0;
        pad_count_next   = '0;
        discarding_next  = !end_of_message;
        if (end_of_message) begin
          total_next = '0;
        end
      end else if (group_pos != 2'd3) begin
        // shift the sextet into the group
        acc_next       = {acc[11:0], sextet};
        group_pos_next = group_pos + 2'd1;
        pad_count_next = pad_new[1:0];
      end else begin
        // group complete: emit bytes, and done on the final group
        push           = 1'b1;
        bundle.nbytes  = nbytes;
        acc_next       = '0;
        group_pos_next = '0;
        pad_count_next = '0;
        total_next     = sat_total;
        if (end_of_message) begin
          bundle.has_tail  = 1'b1;
          bundle.tail_kind = KIND_DONE;
          bundle.count     = count16;
          total_next       = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      group_pos  <= '0;
      pad_count  <= '0;
      discarding <= 1'b0;
      total      <= '0;
    end else begin
      acc        <= acc_next;
      group_pos  <= group_pos_next;
      pad_count  <= pad_count_next;
      discarding <= discarding_next;
      total      <= total_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/b64d_bundle_fifo.sv
// Two-entry queue of result bundles between the decoder and the serializer.
// Depends on b64d_pkg.
`default_nettype none

module b64d_bundle_fifo import b64d_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  bundle_t      push_data,
  input  wire logic    pop,
  output logic         full,
  output logic         not_empty,
  output bundle_t      head
);

  bundle_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  // Store the pushed bundle
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/b64d_serializer.sv
// Unpacks one bundle into single results on the output channel.
// Depends on b64d_pkg; fed from b64d_bundle_fifo.
`default_nettype none

module b64d_serializer import b64d_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   avail,
  input  bundle_t     head,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [15:0] byte_count,
  output logic        last_of_run
);

  bundle_t    cur;
  logic       cur_valid;
  logic [1:0] pos;
  logic [2:0] total;
  logic       is_byte;
  logic       done_req;

  assign total       = {1'b0, cur.nbytes} + {2'b00, cur.has_tail};
  assign is_byte     = ({1'b0, pos} < {1'b0, cur.nbytes});
  assign last_of_run = ({1'b0, pos} == total - 3'd1);
  assign out_valid   = cur_valid;
  assign done_req    = cur_valid && !out_stall && last_of_run;
  assign pop         = avail && (!cur_valid || done_req);

  // Select the field values for the current position
  always_comb begin
    case (pos)
      2'd0:    data_byte = cur.word[23:16];
      2'd1:    data_byte = cur.word[15:8];
      2'd2:    data_byte = cur.word[7:0];
      default: data_byte = 8'd0;
    endcase
    if (is_byte) begin
      kind       = KIND_DATA;
      byte_count = 16'd0;
    end else begin
      kind       = cur.tail_kind;
      data_byte  = 8'd0;
      byte_count = (cur.tail_kind == KIND_DONE) ? cur.count : 16'd0;
    end
  end

  // Load the next bundle or step through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      pos       <= 2'd0;
    end else if (done_req) begin
      cur_valid <= 1'b0;
      pos       <= 2'd0;
    end else if (cur_valid && !out_stall) begin
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_base64_stream_decoder.sv
// Self-checking testbench for base64_stream_decoder: directed table and random messages;
// random messages and some directed rows are checked against an in-bench decoder model.
// Depends on b64d_pkg and the base64_stream_decoder RTL.
`timescale 1ns / 100ps

module tb_base64_stream_decoder;
  import b64d_pkg::*;

  localparam int RANDOM_ITEMS = 156;
  localparam int HOLD_CYCLES  = 80;
  localparam int COUNT_MAX    = 65535;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_count;
    logic        last_of_run;
  } result_t;

  typedef enum logic [1:0] {FROM_MODEL, NO_RESULT, ONE_ERROR} check_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eom;
    check_t     chk;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  character;
  logic        end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_count;
  logic        last_of_run;

  // Decoder model state
  logic [17:0] sextet_acc;
  logic [1:0]  grp_pos;
  logic [2:0]  pad_cnt;
  bit          skipping;
  int          msg_total;

  result_t     char_results[$];     // results caused by the latest character
  result_t     pending_results[$];  // results still owed by the block
  int          fail_count = 0;
  int          chars_sent = 0;
  bit          steady = 0;          // no random gaps on either side while set
  bit          hold_req = 0;        // ask the receiver for one long hold-off

  string b64_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Directed messages; typed checks only where the outcome is obvious
  stim_row_t directed_rows [24] = '{
    // "////" clean end: three 0xFF bytes then done
    '{8'h2F, 1'b0, NO_RESULT}, '{8'h2F, 1'b0, NO_RESULT}, '{8'h2F, 1'b0, NO_RESULT},
    '{8'h2F, 1'b1, FROM_MODEL},
    // "Za9+" alphabet edges, clean end
    '{8'h5A, 1'b0, NO_RESULT}, '{8'h61, 1'b0, NO_RESULT}, '{8'h39, 1'b0, NO_RESULT},
    '{8'h2B, 1'b1, FROM_MODEL},
    // "AA==" padded group without end mark, then discard up to the mark
    '{8'h41, 1'b0, NO_RESULT}, '{8'h41, 1'b0, NO_RESULT}, '{PAD_CHAR, 1'b0, NO_RESULT},
    '{PAD_CHAR, 1'b0, ONE_ERROR}, '{8'h00, 1'b1, NO_RESULT},
    // invalid character carrying the end mark
    '{8'hFF, 1'b1, ONE_ERROR},
    // "A=B" data after pad, then discard
    '{8'h41, 1'b0, NO_RESULT}, '{PAD_CHAR, 1'b0, NO_RESULT}, '{8'h42, 1'b0, ONE_ERROR},
    '{8'h7A, 1'b1, NO_RESULT},
    // "Q===" third pad
    '{8'h51, 1'b0, NO_RESULT}, '{PAD_CHAR, 1'b0, NO_RESULT}, '{PAD_CHAR, 1'b0, NO_RESULT},
    '{PAD_CHAR, 1'b1, ONE_ERROR},
    // "QQ" message ends mid-group
    '{8'h51, 1'b0, NO_RESULT}, '{8'h51, 1'b1, ONE_ERROR}
  };

  base64_stream_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .character      (character),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .data_byte      (data_byte),
    .byte_count     (byte_count),
    .last_of_run    (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Map a character to {not_in_alphabet, sextet}
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    for (int i = 0; i < 64; i++) begin
      if (b64_alphabet[i] == ch) return {1'b0, 6'(i)};
    end
    return 7'h40;
  endfunction

  function automatic void clear_message();
    sextet_acc = '0;
    grp_pos    = '0;
    pad_cnt    = '0;
    skipping   = 1'b0;
    msg_total  = 0;
  endfunction

  // Decode one character; fill char_results with what it causes
  function automatic void decode_char(input logic [7:0] ch, input logic eom);
    logic       bad;
    logic [6:0] look;
    logic [5:0] sextet;
    logic [23:0] word;
    int         nbytes;
    char_results.delete();
    bad    = 1'b0;
    sextet = '0;
    if (skipping) begin
      if (eom) clear_message();
      return;
    end
    if (ch == PAD_CHAR) begin
      pad_cnt = pad_cnt + 3'd1;
      if (pad_cnt > 3'd2) bad = 1'b1;
    end else if (pad_cnt != 0) begin
      bad = 1'b1;
    end else begin
      look   = sextet_of(ch);
      bad    = look[6];
      sextet = look[5:0];
    end
    if (!bad && grp_pos == 2'd3 && pad_cnt != 0 && !eom) bad = 1'b1;
    if (!bad && grp_pos != 2'd3 && eom) bad = 1'b1;
    // drop the group, report once, then skip to the end mark
    if (bad) begin
      char_results.push_back('{KIND_ERROR, 8'd0, 16'd0, 1'b1});
      if (eom) begin
        clear_message();
      end else begin
        sextet_acc = '0;
        grp_pos    = '0;
        pad_cnt    = '0;
        skipping   = 1'b1;
      end
      return;
    end
    if (grp_pos != 2'd3) begin
      sextet_acc = {sextet_acc[11:0], sextet};
      grp_pos    = grp_pos + 2'd1;
      return;
    end
    // group complete: emit bytes most significant first
    word   = {sextet_acc, sextet};
    nbytes = 3 - int'(pad_cnt);
    for (int i = 0; i < nbytes; i++) begin
      char_results.push_back('{KIND_DATA, word[23 - 8 * i -: 8], 16'd0, 1'b0});
    end
    msg_total  = (msg_total + nbytes > COUNT_MAX) ? COUNT_MAX : msg_total + nbytes;
    sextet_acc = '0;
    grp_pos    = '0;
    pad_cnt    = '0;
    if (eom) begin
      char_results.push_back('{KIND_DONE, 8'd0, 16'(msg_total), 1'b0});
      clear_message();
    end
    if (char_results.size() > 0) char_results[$].last_of_run = 1'b1;
  endfunction

  // Mostly no idling, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] random_b64_char();
    return b64_alphabet[$urandom_range(0, 63)];
  endfunction

  // Offer one request, wait for it to be taken, record what it owes
  task automatic send_char(input logic [7:0] ch, input logic eom, input check_t chk);
    int gap;
    in_valid       <= 1'b1;
    character      <= ch;
    end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    decode_char(ch, eom);
    case (chk)
      FROM_MODEL: foreach (char_results[i]) pending_results.push_back(char_results[i]);
      ONE_ERROR:  pending_results.push_back('{KIND_ERROR, 8'd0, 16'd0, 1'b1});
      default: ;
    endcase
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold the sender until every owed result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Well-formed message, a broken one, or noise
  task automatic send_random_message(input bit clean_only);
    logic [7:0] msg[$];
    int groups, pads, sel, pos, cut;
    groups = $urandom_range(1, 5);
    pads   = $urandom_range(0, 2);
    for (int g = 0; g < groups; g++) begin
      for (int i = 0; i < 4; i++) begin
        if (g == groups - 1 && i >= 4 - pads) msg.push_back(PAD_CHAR);
        else msg.push_back(random_b64_char());
      end
    end
    sel = clean_only ? 0 : $urandom_range(0, 99);
    if (sel >= 85) begin
      // noise: random bytes of random length
      msg.delete();
      repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(0, 255)));
    end else if (sel >= 70) begin
      pos = $urandom_range(0, msg.size() - 1);
      case ($urandom_range(0, 3))
        0: msg[pos] = 8'($urandom_range(0, 255));
        1: begin
          cut = $urandom_range(1, 3);
          repeat (cut) msg.pop_back();
          if (msg.size() == 0) msg.push_back(random_b64_char());
        end
        2: msg.insert(pos, PAD_CHAR);
        default: repeat (4) msg.push_back(random_b64_char());
      endcase
    end
    foreach (msg[i]) send_char(msg[i], i == msg.size() - 1, FROM_MODEL);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int stretch;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        stretch = pick_gap();
        if (stretch == 0) begin
          out_stall <= 1'b0;
          @(negedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (stretch) @(negedge clk);
        end
      end
    end
  end

  // Compare each result with the oldest one owed
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with none owed: kind %0d data_byte %0h byte_count %0d",
               kind, data_byte, byte_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
          fail_count++;
        end
        if (data_byte !== want.data_byte) begin
          $error("data_byte mismatch: expected %0h, actual %0h", want.data_byte, data_byte);
          fail_count++;
        end
        if (byte_count !== want.byte_count) begin
          $error("byte_count mismatch: expected %0d, actual %0d",
                 want.byte_count, byte_count);
          fail_count++;
        end
        if (last_of_run !== want.last_of_run) begin
          $error("last_of_run mismatch: expected %0b, actual %0b",
                 want.last_of_run, last_of_run);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int msg_no;
    rst            = 1'b1;
    in_valid       = 1'b0;
    character      = 8'd0;
    end_of_message = 1'b0;
    clear_message();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table
    foreach (directed_rows[i])
      send_char(directed_rows[i].ch, directed_rows[i].eom, directed_rows[i].chk);

    // Random messages
    msg_no = 0;
    while (chars_sent < $size(directed_rows) + RANDOM_ITEMS) begin
      msg_no++;
      steady = ($urandom_range(0, 3) == 0);
      if (msg_no == 5) begin
        // long receiver hold-off while the sender keeps pushing
        hold_req = 1'b1;
        steady   = 1'b1;
        repeat (3) send_random_message(1'b1);
        steady   = 1'b0;
      end
      if (msg_no == 2 || msg_no == 12) drain_results();
      send_random_message(1'b0);
    end

    // Wait out the tail, then allow for stray results
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/b64d_pkg.sv
rtl/core/b64d_decode.sv
rtl/core/b64d_bundle_fifo.sv
rtl/core/b64d_serializer.sv
rtl/core/base64_stream_decoder.sv
dv/tb_base64_stream_decoder.sv
